>>> design/wrap_aware_timer_table_macros.svh
// Assertion macros shared by the timer table checker.
// Depends on nothing; the including scope provides clk and rst_n.
`ifndef WRAP_AWARE_TIMER_TABLE_MACROS_SVH
`define WRAP_AWARE_TIMER_TABLE_MACROS_SVH

// Property that must hold at every sampled edge outside reset.
`define WATT_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Property with a non-overlapping implication from antecedent to consequent.
`define WATT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/watt_pkg.sv
// Package for the wrap-aware timer table: sizes, codes and beat types.
// Depends on nothing; the design and checker files refer to it by scoped names.
package watt_pkg;

    localparam int MAX_TIMERS = 16;
    localparam int TICK_BITS  = 32;
    localparam int TW         = TICK_BITS;
    localparam int IW         = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int UW         = $clog2(MAX_TIMERS + 1);
    localparam int QDEPTH     = 2;
    localparam int QPW        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW        = $clog2(QDEPTH + 1);

    typedef enum logic [0:0] {
        CMD_TICK = 1'b0,
        CMD_ADD  = 1'b1
    } cmd_code_t;

    typedef enum logic [1:0] {
        KIND_FIRED = 2'd0,
        KIND_ADDED = 2'd1,
        KIND_FULL  = 2'd2
    } kind_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] now;
        logic [31:0] delay;
        logic        one_shot;
        logic [7:0]  callback_id;
    } req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] fired_id;
        logic [3:0] slot;
        logic       last;
    } rsp_t;

    // Classified command as it travels from the front to the back.
    typedef struct packed {
        logic          is_add;
        logic [TW-1:0] now;
        logic [TW-1:0] delay;
        logic [TW-1:0] deadline;
        logic          wrap;
        logic          one_shot;
        logic [7:0]    id;
    } cmd_t;

endpackage

>>> design/wrap_aware_timer_table.sv
// Wrap-aware timer table, top level. Depends on watt_pkg, watt_front,
// watt_queue and watt_back.
//
// An add request passes through the front register, the command queue and
// the back end's output register to its single result beat. A tick request
// walks the used table entries one per cycle in the back end while the result
// channel takes its beats. Fired timers come out in slot order, the final one
// marked with last; a tick with nothing due gives no beat. Requests keep being
// accepted into a two-entry command queue while the back end works.
module wrap_aware_timer_table (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  watt_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output watt_pkg::rsp_t  rsp
);

    logic           f_push;
    logic           f_push_ready;
    watt_pkg::cmd_t f_cmd;
    logic           q_valid;
    logic           q_pop;
    watt_pkg::cmd_t q_cmd;

    watt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push       (f_push),
        .push_ready (f_push_ready),
        .cmd        (f_cmd)
    );

    watt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_push),
        .push_ready (f_push_ready),
        .push_data  (f_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_cmd)
    );

    watt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_pop   (q_pop),
        .cmd       (q_cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

>>> design/watt_front.sv
// Front end of the timer table: accepts request beats, masks the time fields
// and precomputes the deadline of an add. Depends on watt_pkg.
module watt_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  watt_pkg::req_t  req,
    output logic            push,
    input  logic            push_ready,
    output watt_pkg::cmd_t  cmd
);

    logic           valid_reg;
    watt_pkg::cmd_t cmd_reg;
    logic [watt_pkg::TW-1:0] now_m;
    logic [watt_pkg::TW-1:0] dly_m;
    logic [watt_pkg::TW-1:0] sum;

    assign req_ready = !valid_reg || push_ready;
    assign push      = valid_reg;
    assign cmd       = cmd_reg;

    assign now_m = watt_pkg::TW'(req.now);
    assign dly_m = watt_pkg::TW'(req.delay);
    assign sum   = now_m + dly_m;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            cmd_reg.is_add   <= (req.cmd == watt_pkg::CMD_ADD);
            cmd_reg.now      <= now_m;
            cmd_reg.delay    <= dly_m;
            cmd_reg.deadline <= sum;
            cmd_reg.wrap     <= now_m > sum;
            cmd_reg.one_shot <= req.one_shot;
            cmd_reg.id       <= req.callback_id;
        end
    end

endmodule

>>> design/watt_queue.sv
// Short command queue between the front and the back of the timer table.
// Depends on watt_pkg.
module watt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            push_ready,
    input  watt_pkg::cmd_t  push_data,
    output logic            pop_valid,
    input  logic            pop,
    output watt_pkg::cmd_t  pop_data
);

    watt_pkg::cmd_t              mem_reg [watt_pkg::QDEPTH];
    logic [watt_pkg::QPW-1:0]    wr_reg;
    logic [watt_pkg::QPW-1:0]    rd_reg;
    logic [watt_pkg::QCW-1:0]    cnt_reg;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (cnt_reg != watt_pkg::QCW'(watt_pkg::QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    function automatic logic [watt_pkg::QPW-1:0] bump(input logic [watt_pkg::QPW-1:0] p);
        if (p == watt_pkg::QPW'(watt_pkg::QDEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= bump(wr_reg);
            if (do_pop)
                rd_reg <= bump(rd_reg);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule

>>> design/watt_back.sv
// Back end of the timer table (depends on watt_pkg): holds the timer entries,
// carries out adds and on a tick walks one entry per cycle unless stalled.
module watt_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_pop,
    input  watt_pkg::cmd_t  cmd,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output watt_pkg::rsp_t  rsp
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic [watt_pkg::UW-1:0] used_reg, used_next;
    logic [watt_pkg::TW-1:0] prev_reg, prev_next;
    logic [watt_pkg::UW-1:0] walk_reg, walk_next;
    logic [watt_pkg::TW-1:0] tnow_reg, tnow_next;
    logic                    twrap_reg, twrap_next;
    logic                    held_valid_reg, held_valid_next;
    watt_pkg::rsp_t          held_reg, held_next;
    logic                    out_valid_reg, out_valid_next;
    watt_pkg::rsp_t          out_reg, out_next;

    logic [watt_pkg::TW-1:0] dl_reg   [watt_pkg::MAX_TIMERS];
    logic [watt_pkg::TW-1:0] per_reg  [watt_pkg::MAX_TIMERS];
    logic [7:0]              hdl_reg  [watt_pkg::MAX_TIMERS];
    logic                    once_reg [watt_pkg::MAX_TIMERS];
    logic                    freed_reg[watt_pkg::MAX_TIMERS];
    logic                    wp_reg   [watt_pkg::MAX_TIMERS];

    logic                    can_push;
    logic                    found;
    logic [watt_pkg::IW-1:0] free_idx;
    logic [watt_pkg::IW-1:0] add_slot;
    logic                    full;
    logic                    add_do;
    logic                    tick_do;
    logic [watt_pkg::IW-1:0] idx;
    logic [watt_pkg::TW-1:0] cur_dl;
    logic [watt_pkg::TW-1:0] adv_dl;
    logic                    wp_eff;
    logic                    due;
    logic                    fire;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign can_push  = !out_valid_reg || rsp_ready;

    // Lowest freed slot among the entries in use.
    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = watt_pkg::MAX_TIMERS - 1; i >= 0; i--)
        begin
            if (watt_pkg::UW'(i) < used_reg && freed_reg[i])
            begin
                found    = 1'b1;
                free_idx = watt_pkg::IW'(i);
            end
        end
    end

    assign full     = !found && (used_reg == watt_pkg::UW'(watt_pkg::MAX_TIMERS));
    assign add_slot = found ? free_idx : watt_pkg::IW'(used_reg);

    assign idx    = walk_reg[watt_pkg::IW-1:0];
    assign cur_dl = dl_reg[idx];
    assign adv_dl = cur_dl + per_reg[idx];
    assign wp_eff = twrap_reg ? 1'b0 : wp_reg[idx];
    assign due    = (cur_dl <= tnow_reg) || (twrap_reg && (prev_reg <= cur_dl));
    assign fire   = !freed_reg[idx] && !wp_eff && due;

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        prev_next       = prev_reg;
        walk_next       = walk_reg;
        tnow_next       = tnow_reg;
        twrap_next      = twrap_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_next        = out_reg;
        cmd_pop         = 1'b0;
        add_do          = 1'b0;
        tick_do         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.is_add)
                    begin
                        if (can_push)
                        begin
                            cmd_pop           = 1'b1;
                            out_valid_next    = 1'b1;
                            out_next.fired_id = cmd.id;
                            out_next.last     = 1'b1;
                            if (full)
                            begin
                                out_next.kind = watt_pkg::KIND_FULL;
                                out_next.slot = 4'd0;
                            end
                            else
                            begin
                                add_do        = 1'b1;
                                out_next.kind = watt_pkg::KIND_ADDED;
                                out_next.slot = 4'(add_slot);
                                if (!found)
                                    used_next = used_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        cmd_pop         = 1'b1;
                        tnow_next       = cmd.now;
                        twrap_next      = cmd.now < prev_reg;
                        walk_next       = '0;
                        held_valid_next = 1'b0;
                        state_next      = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (walk_reg == used_reg)
                begin
                    // The last fired timer is held back until the walk ends so
                    // that it can carry the final-beat mark.
                    if (!held_valid_reg || can_push)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = held_reg;
                            out_next.last  = 1'b1;
                        end
                        held_valid_next = 1'b0;
                        prev_next       = tnow_reg;
                        state_next      = ST_IDLE;
                    end
                end
                else if (!(fire && held_valid_reg && !can_push))
                begin
                    tick_do   = 1'b1;
                    walk_next = walk_reg + 1'b1;
                    if (fire)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = held_reg;
                            out_next.last  = 1'b0;
                        end
                        held_valid_next    = 1'b1;
                        held_next.kind     = watt_pkg::KIND_FIRED;
                        held_next.fired_id = hdl_reg[idx];
                        held_next.slot     = 4'(idx);
                        held_next.last     = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            prev_reg       <= '0;
            walk_reg       <= '0;
            twrap_reg      <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            prev_reg       <= prev_next;
            walk_reg       <= walk_next;
            twrap_reg      <= twrap_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tnow_reg <= tnow_next;
        held_reg <= held_next;
        out_reg  <= out_next;
        if (add_do)
        begin
            dl_reg[add_slot]    <= cmd.deadline;
            per_reg[add_slot]   <= cmd.delay;
            hdl_reg[add_slot]   <= cmd.id;
            once_reg[add_slot]  <= cmd.one_shot;
            freed_reg[add_slot] <= 1'b0;
            wp_reg[add_slot]    <= cmd.wrap;
        end
        if (tick_do)
        begin
            if (fire && once_reg[idx])
            begin
                freed_reg[idx] <= 1'b1;
                wp_reg[idx]    <= wp_eff;
            end
            else if (fire)
            begin
                dl_reg[idx] <= adv_dl;
                wp_reg[idx] <= cur_dl > adv_dl;
            end
            else
            begin
                wp_reg[idx] <= wp_eff;
            end
        end
    end

endmodule

>>> design/watt_checker.sv
// Port-level checker for the timer table, bound to the top level.
// Depends on watt_pkg and wrap_aware_timer_table_macros.svh.
`include "wrap_aware_timer_table_macros.svh"

module watt_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_ready,
    input  watt_pkg::req_t  req,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  watt_pkg::rsp_t  rsp
);

    `WATT_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req), "req moved")
    `WATT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp moved")
    `WATT_ASSERT(a_kind_legal, !rsp_valid || rsp.kind <= watt_pkg::KIND_FULL, "bad result kind")
    `WATT_ASSERT(a_add_last, !rsp_valid || rsp.kind == watt_pkg::KIND_FIRED || rsp.last, "add not last")
    `WATT_ASSERT(a_full_slot, !rsp_valid || rsp.kind != watt_pkg::KIND_FULL || rsp.slot == 4'd0, "full slot")

endmodule

bind wrap_aware_timer_table watt_checker u_watt_checker (.*);
